/* sv/tggm_pkg.sv */
// tggm_pkg: shared widths, limits and types for the throttle-gated gain mixer
// used by tggm_div and throttle_gated_gain_mixer_unit; no dependencies
package tggm_pkg;

    localparam int GAIN_DEPTH = 8;
    localparam int SLOT_W     = $clog2(GAIN_DEPTH);
    localparam int SUM_W      = 40;
    localparam int DIV_N_W    = 33;
    localparam int DIV_D_W    = 16;
    localparam int DIV_CNT_W  = $clog2(DIV_N_W + 1);

    typedef logic signed [SUM_W-1:0] tggm_sum_t;

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] dividend;
        logic [DIV_D_W-1:0] divisor;
    } tggm_div_req_t;

    typedef struct packed {
        logic               done;
        logic [DIV_N_W-1:0] quotient;
    } tggm_div_rsp_t;

    function automatic tggm_sum_t sat_add(input tggm_sum_t a, input logic signed [31:0] b);
        logic signed [SUM_W:0] s;
        tggm_sum_t             r;
        s = {a[SUM_W-1], a} + {{(SUM_W-31){b[31]}}, b};
        if (s[SUM_W] != s[SUM_W-1])
        begin
            r = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end
        else
        begin
            r = s[SUM_W-1:0];
        end
        return r;
    endfunction

endpackage

/* sv/tggm_div.sv */
// tggm_div: restoring serial divider, one quotient bit per cycle
// depends on tggm_pkg for operand widths and request/response types
module tggm_div
    import tggm_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  tggm_div_req_t req,
    output tggm_div_rsp_t rsp
);

    logic [DIV_N_W-1:0]   quo_reg;
    logic [DIV_D_W-1:0]   rem_reg;
    logic [DIV_D_W-1:0]   dvs_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [DIV_D_W:0]     trial;
    logic                 ge;
    logic [DIV_D_W:0]     diff;

    assign trial = {rem_reg, quo_reg[DIV_N_W-1]};
    assign ge    = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIV_N_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
            quo_reg <= {quo_reg[DIV_N_W-2:0], ge};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

/* sv/throttle_gated_gain_mixer_unit.sv */
// channel   | dir | beat contents
// s_axis    | in  | tdata: slot[2:0], value[18:3]; tuser: cmd; tlast: last
// m_axis    | out | tdata: mixed_out[15:0]; tuser: div_fault
// apb       | in  | out_min @0x0, out_max @0x4, trim @0x8, throttle_slot @0xc
// a gain load is written straight from idle; a sample beat passes MUL and ACC through the shared multiplier
// the last beat of a round then goes through SUM, ADD, CLAMP, MUL2, DSTART and the 33-step serial divider;
// a divisor fault goes from CLAMP straight to FIN
// rst_n clears the gain table, the three sums, the state and output valid, and sets the APB registers to their defaults
// a result waits in the output register while the next beat is taken
// top level of the throttle-gated gain mixer; depends on tggm_pkg and tggm_div
module throttle_gated_gain_mixer_unit
    import tggm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // slot[2:0], value[18:3], zero pad
    input  logic        s_tuser,   // cmd
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // mixed_out[15:0]
    output logic        m_tuser,   // div_fault
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [1:0] REG_OUT_MIN = 2'd0;
    localparam logic [1:0] REG_OUT_MAX = 2'd1;
    localparam logic [1:0] REG_TRIM    = 2'd2;
    localparam logic [1:0] REG_THR     = 2'd3;

    localparam logic CMD_LOAD = 1'b0;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_MUL    = 4'd1;
    localparam logic [3:0] ST_ACC    = 4'd2;
    localparam logic [3:0] ST_SUM    = 4'd3;
    localparam logic [3:0] ST_ADD    = 4'd4;
    localparam logic [3:0] ST_CLAMP  = 4'd5;
    localparam logic [3:0] ST_MUL2   = 4'd6;
    localparam logic [3:0] ST_DSTART = 4'd7;
    localparam logic [3:0] ST_DWAIT  = 4'd8;
    localparam logic [3:0] ST_FIN    = 4'd9;

    logic signed [15:0] out_min_reg;
    logic signed [15:0] out_max_reg;
    logic signed [15:0] trim_reg;
    logic [3:0]         thr_slot_reg;

    logic signed [15:0] gain_reg [GAIN_DEPTH];
    tggm_sum_t          pos_reg;
    tggm_sum_t          neg_reg;
    tggm_sum_t          thr_reg;

    logic [3:0]         state_reg;
    logic signed [15:0] val_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic               last_reg;
    logic               route_thr_reg;
    logic signed [50:0] prod_reg;
    tggm_sum_t          tcl_reg;
    logic               use_pos_reg;
    logic               use_neg_reg;
    logic signed [41:0] s_reg;
    logic signed [17:0] fac_reg;
    logic signed [32:0] mb_reg;
    logic               pos_path_reg;
    logic               neg_q_reg;
    logic signed [15:0] res_reg;
    logic               fault_reg;

    logic               m_valid_reg;
    logic [15:0]        m_data_reg;
    logic               m_user_reg;

    logic               s_fire;
    logic               cfg_wr;
    logic               gated;
    logic [SLOT_W-1:0]  in_slot;
    logic signed [15:0] in_val;
    logic signed [15:0] gain_rd;

    logic signed [17:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [50:0] mul_p;

    logic signed [31:0] prod32;
    logic signed [41:0] mn42;
    logic signed [41:0] mx42;
    logic signed [41:0] t42;
    logic               t_lo;
    logic signed [41:0] t1;
    logic               t_hi;
    logic signed [41:0] t2;
    logic signed [41:0] sum_all;
    logic signed [41:0] sc1;
    logic signed [41:0] sc2;
    logic signed [32:0] mn33;
    logic signed [17:0] trim18;
    logic signed [50:0] mag;
    logic signed [33:0] qs;
    logic signed [34:0] rsum;
    logic signed [15:0] rsat;
    logic               out_free;

    tggm_div_req_t      div_req;
    tggm_div_rsp_t      div_rsp;

    tggm_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign in_slot  = s_tdata[SLOT_W-1:0];
    assign in_val   = s_tdata[18:3];
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign gated    = (thr_slot_reg < 4'(GAIN_DEPTH));
    assign gain_rd  = gain_reg[slot_reg];
    assign pready   = 1'b1;

    always_comb
    begin
        case (paddr[3:2])
            REG_OUT_MIN: prdata = {{16{out_min_reg[15]}}, out_min_reg};
            REG_OUT_MAX: prdata = {{16{out_max_reg[15]}}, out_max_reg};
            REG_TRIM:    prdata = {{16{trim_reg[15]}}, trim_reg};
            REG_THR:     prdata = {28'd0, thr_slot_reg};
            default:     prdata = '0;
        endcase
    end

    // shared multiplier: gain product on samples, numerator at round end
    assign mul_a = (state_reg == ST_MUL) ? {{2{val_reg[15]}}, val_reg} : fac_reg;
    assign mul_b = (state_reg == ST_MUL) ? {{17{gain_rd[15]}}, gain_rd} : mb_reg;
    assign mul_p = mul_a * mul_b;

    assign prod32 = prod_reg[31:0];
    assign mn42   = {{11{out_min_reg[15]}}, out_min_reg, 15'd0};
    assign mx42   = {{11{out_max_reg[15]}}, out_max_reg, 15'd0};
    assign mn33   = {{2{out_min_reg[15]}}, out_min_reg, 15'd0};
    assign trim18 = {{2{trim_reg[15]}}, trim_reg};

    // throttle clamp, min first then max
    assign t42  = {{2{thr_reg[SUM_W-1]}}, thr_reg};
    assign t_lo = t42 < mn42;
    assign t1   = t_lo ? mn42 : t42;
    assign t_hi = t1 > mx42;
    assign t2   = t_hi ? mx42 : t1;

    assign sum_all = {{2{tcl_reg[SUM_W-1]}}, tcl_reg}
                   + (use_neg_reg ? {{2{neg_reg[SUM_W-1]}}, neg_reg} : 42'sd0)
                   + (use_pos_reg ? {{2{pos_reg[SUM_W-1]}}, pos_reg} : 42'sd0);

    assign sc1 = (s_reg < mn42) ? mn42 : s_reg;
    assign sc2 = (sc1 > mx42) ? mx42 : sc1;

    assign mag = prod_reg[50] ? -prod_reg : prod_reg;

    assign div_req.start    = (state_reg == ST_DSTART);
    assign div_req.dividend = mag[47:15];
    assign div_req.divisor  = pos_path_reg ? out_max_reg : 16'(-out_min_reg);

    assign qs   = neg_q_reg ? -{1'b0, div_rsp.quotient} : {1'b0, div_rsp.quotient};
    assign rsum = {qs[33], qs} + (pos_path_reg ? {{19{trim_reg[15]}}, trim_reg}
                                               : -35'sd32768);
    always_comb
    begin
        if (rsum > 35'sd32767)
        begin
            rsat = 16'sh7fff;
        end
        else if (rsum < -35'sd32768)
        begin
            rsat = 16'sh8000;
        end
        else
        begin
            rsat = rsum[15:0];
        end
    end

    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_min_reg  <= -16'sd4096;
            out_max_reg  <= 16'sd4096;
            trim_reg     <= '0;
            thr_slot_reg <= 4'(GAIN_DEPTH);
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_OUT_MIN: out_min_reg  <= pwdata[15:0];
                REG_OUT_MAX: out_max_reg  <= pwdata[15:0];
                REG_TRIM:    trim_reg     <= pwdata[15:0];
                REG_THR:     thr_slot_reg <= pwdata[3:0];
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            pos_reg     <= '0;
            neg_reg     <= '0;
            thr_reg     <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < GAIN_DEPTH; i++)
            begin
                gain_reg[i] <= '0;
            end
        end
        else
        begin
            if (m_valid_reg && m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_fire)
                    begin
                        if (s_tuser == CMD_LOAD)
                        begin
                            gain_reg[in_slot] <= in_val;
                        end
                        else
                        begin
                            state_reg <= ST_MUL;
                        end
                    end
                end
                ST_MUL:
                begin
                    state_reg <= ST_ACC;
                end
                ST_ACC:
                begin
                    if (route_thr_reg)
                    begin
                        thr_reg <= sat_add(thr_reg, prod32);
                    end
                    else if (!prod32[31] && prod32 != 32'sd0)
                    begin
                        pos_reg <= sat_add(pos_reg, prod32);
                    end
                    else if (prod32[31])
                    begin
                        neg_reg <= sat_add(neg_reg, prod32);
                    end
                    state_reg <= last_reg ? ST_SUM : ST_IDLE;
                end
                ST_SUM:
                begin
                    state_reg <= ST_ADD;
                end
                ST_ADD:
                begin
                    pos_reg   <= '0;
                    neg_reg   <= '0;
                    thr_reg   <= '0;
                    state_reg <= ST_CLAMP;
                end
                ST_CLAMP:
                begin
                    if (!sc2[41])
                    begin
                        state_reg <= (out_max_reg[15] || out_max_reg == 16'sd0) ? ST_FIN
                                                                                : ST_MUL2;
                    end
                    else
                    begin
                        state_reg <= !out_min_reg[15] ? ST_FIN : ST_MUL2;
                    end
                end
                ST_MUL2:
                begin
                    state_reg <= ST_DSTART;
                end
                ST_DSTART:
                begin
                    state_reg <= ST_DWAIT;
                end
                ST_DWAIT:
                begin
                    if (div_rsp.done)
                    begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN:
                begin
                    if (out_free)
                    begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                val_reg       <= in_val;
                slot_reg      <= in_slot;
                last_reg      <= s_tlast;
                route_thr_reg <= gated && (thr_slot_reg[SLOT_W-1:0] == in_slot);
            end
            ST_MUL:
            begin
                prod_reg <= mul_p;
            end
            ST_SUM:
            begin
                tcl_reg     <= gated ? t2[SUM_W-1:0] : thr_reg;
                use_neg_reg <= gated ? !t_lo : 1'b1;
                use_pos_reg <= gated ? !t_hi : 1'b1;
            end
            ST_ADD:
            begin
                s_reg <= sum_all;
            end
            ST_CLAMP:
            begin
                pos_path_reg <= !sc2[41];
                res_reg      <= '0;
                fault_reg    <= 1'b1;
                if (!sc2[41])
                begin
                    fac_reg <= 18'sd32768 - trim18;
                    mb_reg  <= sc2[32:0];
                end
                else
                begin
                    fac_reg <= 18'sd32768 + trim18;
                    mb_reg  <= sc2[32:0] - mn33;
                end
            end
            ST_MUL2:
            begin
                prod_reg <= mul_p;
            end
            ST_DSTART:
            begin
                neg_q_reg <= prod_reg[50];
            end
            ST_DWAIT:
            begin
                if (div_rsp.done)
                begin
                    res_reg   <= rsat;
                    fault_reg <= 1'b0;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    m_data_reg <= res_reg;
                    m_user_reg <= fault_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

/* verif/tb_top.sv */
// tb_top: self-checking bench for throttle_gated_gain_mixer_unit: a directed table, then random
// mixing rounds under several register settings and stall patterns, then a saturation run,
// checked by a built-in mixer model; depends on tggm_pkg and the unit under test
module tb_top;
    import tggm_pkg::*;

    localparam int     DRAIN_CYCLES = 64;
    localparam int     PHASE_SAMPLES = 30;
    localparam int     OVERFLOW_BEATS = 515;
    localparam longint ACC_HI = (longint'(1) <<< (SUM_W - 1)) - 1;
    localparam longint ACC_LO = -(longint'(1) <<< (SUM_W - 1));

    typedef enum logic { CMD_LOAD = 1'b0, CMD_SAMPLE = 1'b1 } cmd_e;
    typedef enum logic [1:0] { REG_OUT_MIN, REG_OUT_MAX, REG_TRIM, REG_THROTTLE_SLOT } reg_idx_e;
    typedef enum logic { ROW_BEAT, ROW_CFG } row_kind_e;

    typedef struct packed {
        logic signed [15:0] mixed;
        logic               fault;
    } mix_res_t;

    typedef struct packed {
        row_kind_e          kind;
        reg_idx_e           regsel;
        cmd_e               cmd;
        logic [2:0]         slot;
        logic signed [15:0] value;
        logic               last;
        logic               typed;
        logic signed [15:0] typ_out;
        logic               typ_fault;
    } dir_row_t;

    localparam int N_DIRECTED = 37;
    localparam dir_row_t DIRECTED [0:N_DIRECTED-1] = '{
        // gains are zero after reset
        '{ROW_BEAT, REG_OUT_MIN, CMD_SAMPLE, 3'd0, 16'sd32767, 1'b1, 1'b1, 16'sd0, 1'b0},
        // last on a load gives nothing
        '{ROW_BEAT, REG_OUT_MIN, CMD_LOAD,   3'd0, 16'sd4096,  1'b1, 1'b0, 16'sd0, 1'b0},
        '{ROW_BEAT, REG_OUT_MIN, CMD_SAMPLE, 3'd0, 16'sd32767, 1'b1, 1'b1, 16'sd32767, 1'b0},
        '{ROW_BEAT, REG_OUT_MIN, CMD_SAMPLE, 3'd0, 16'h8000,   1'b1, 1'b1, 16'h8000, 1'b0},
        '{ROW_BEAT, REG_OUT_MIN, CMD_LOAD,   3'd7, 16'h8000,   1'b0, 1'b0, 16'sd0, 1'b0},
        '{ROW_BEAT, REG_OUT_MIN, CMD_LOAD,   3'd1, 16'sd32767, 1'b0, 1'b0, 16'sd0, 1'b0},
        // repeated slot in one round
        '{ROW_BEAT, REG_OUT_MIN, CMD_SAMPLE, 3'd1, 16'sd1000,  1'b0, 1'b0, 16'sd0, 1'b0},
        '{ROW_BEAT, REG_OUT_MIN, CMD_SAMPLE, 3'd7, -16'sd20,   1'b0, 1'b0, 16'sd0, 1'b0},
        '{ROW_BEAT, REG_OUT_MIN, CMD_SAMPLE, 3'd1, -16'sd500,  1'b1, 1'b0, 16'sd0, 1'b0},
        '{ROW_BEAT, REG_OUT_MIN, CMD_SAMPLE, 3'd2, 16'sd0,     1'b1, 1'b1, 16'sd0, 1'b0},
        // largest product, clamped and saturated
        '{ROW_BEAT, REG_OUT_MIN, CMD_LOAD,   3'd6, 16'h8000,   1'b0, 1'b0, 16'sd0, 1'b0},
        '{ROW_BEAT, REG_OUT_MIN, CMD_SAMPLE, 3'd6, 16'h8000,   1'b1, 1'b1, 16'sd32767, 1'b0},
        // throttle gating on slot 1
        '{ROW_CFG,  REG_TRIM,          CMD_LOAD, 3'd0, 16'sd32767, 1'b0, 1'b0, 16'sd0, 1'b0},
        '{ROW_CFG,  REG_THROTTLE_SLOT, CMD_LOAD, 3'd0, 16'sd1,     1'b0, 1'b0, 16'sd0, 1'b0},
        '{ROW_BEAT, REG_OUT_MIN, CMD_LOAD,   3'd2, 16'sd200,   1'b0, 1'b0, 16'sd0, 1'b0},
        '{ROW_BEAT, REG_OUT_MIN, CMD_SAMPLE, 3'd1, -16'sd30000, 1'b0, 1'b0, 16'sd0, 1'b0},
        '{ROW_BEAT, REG_OUT_MIN, CMD_SAMPLE, 3'd2, -16'sd5000, 1'b0, 1'b0, 16'sd0, 1'b0},
        '{ROW_BEAT, REG_OUT_MIN, CMD_SAMPLE, 3'd7, 16'sd100,   1'b1, 1'b0, 16'sd0, 1'b0},
        // throttle missing from the round
        '{ROW_BEAT, REG_OUT_MIN, CMD_SAMPLE, 3'd0, 16'sd5000,  1'b1, 1'b0, 16'sd0, 1'b0},
        // throttle twice plus a zero product
        '{ROW_BEAT, REG_OUT_MIN, CMD_SAMPLE, 3'd1, 16'sd100,   1'b0, 1'b0, 16'sd0, 1'b0},
        '{ROW_BEAT, REG_OUT_MIN, CMD_SAMPLE, 3'd1, 16'sd0,     1'b1, 1'b0, 16'sd0, 1'b0},
        // divisor faults
        '{ROW_CFG,  REG_OUT_MAX, CMD_LOAD,   3'd0, 16'sd0,     1'b0, 1'b0, 16'sd0, 1'b0},
        '{ROW_BEAT, REG_OUT_MIN, CMD_SAMPLE, 3'd0, 16'sd100,   1'b1, 1'b1, 16'sd0, 1'b1},
        '{ROW_CFG,  REG_OUT_MIN, CMD_LOAD,   3'd0, 16'sd0,     1'b0, 1'b0, 16'sd0, 1'b0},
        '{ROW_BEAT, REG_OUT_MIN, CMD_SAMPLE, 3'd0, -16'sd100,  1'b1, 1'b1, 16'sd0, 1'b1},
        // min above max
        '{ROW_CFG,  REG_OUT_MIN, CMD_LOAD,   3'd0, 16'sd100,   1'b0, 1'b0, 16'sd0, 1'b0},
        '{ROW_CFG,  REG_OUT_MAX, CMD_LOAD,   3'd0, -16'sd100,  1'b0, 1'b0, 16'sd0, 1'b0},
        '{ROW_BEAT, REG_OUT_MIN, CMD_SAMPLE, 3'd0, 16'sd1000,  1'b1, 1'b0, 16'sd0, 1'b0},
        // register extremes, throttle slot above range
        '{ROW_CFG,  REG_OUT_MIN,       CMD_LOAD, 3'd0, 16'h8000,   1'b0, 1'b0, 16'sd0, 1'b0},
        '{ROW_CFG,  REG_OUT_MAX,       CMD_LOAD, 3'd0, 16'sd32767, 1'b0, 1'b0, 16'sd0, 1'b0},
        '{ROW_CFG,  REG_TRIM,          CMD_LOAD, 3'd0, 16'h8000,   1'b0, 1'b0, 16'sd0, 1'b0},
        '{ROW_CFG,  REG_THROTTLE_SLOT, CMD_LOAD, 3'd0, 16'sd15,    1'b0, 1'b0, 16'sd0, 1'b0},
        '{ROW_BEAT, REG_OUT_MIN, CMD_SAMPLE, 3'd0, 16'h8000,   1'b1, 1'b0, 16'sd0, 1'b0},
        '{ROW_BEAT, REG_OUT_MIN, CMD_SAMPLE, 3'd1, 16'sd32767, 1'b1, 1'b0, 16'sd0, 1'b0},
        '{ROW_CFG,  REG_THROTTLE_SLOT, CMD_LOAD, 3'd0, 16'sd7,     1'b0, 1'b0, 16'sd0, 1'b0},
        '{ROW_BEAT, REG_OUT_MIN, CMD_SAMPLE, 3'd7, 16'sd32767, 1'b0, 1'b0, 16'sd0, 1'b0},
        '{ROW_BEAT, REG_OUT_MIN, CMD_SAMPLE, 3'd6, 16'sd32767, 1'b1, 1'b0, 16'sd0, 1'b0}
    };

    localparam int SEND_IDLE [0:3] = '{0, 55, 0, 37};
    localparam int RECV_STALL [0:3] = '{0, 0, 55, 37};

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;    // slot[2:0], value[18:3], zero pad
    logic        s_tuser  = 1'b0;  // cmd
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;          // mixed_out[15:0]
    logic        m_tuser;          // div_fault
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    throttle_gated_gain_mixer_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // mixer model state
    logic signed [15:0] gain_q [GAIN_DEPTH];
    longint             pos_acc;
    longint             neg_acc;
    longint             thr_acc;
    logic signed [15:0] cfg_min;
    logic signed [15:0] cfg_max;
    logic signed [15:0] cfg_trim;
    logic [3:0]         cfg_thr;

    mix_res_t pending_outputs [$];
    mix_res_t want;
    int       err_count = 0;
    int       idle_pct = 0;
    int       stall_pct = 0;
    int       samples_sent = 0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #24000000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic longint clamp_acc(input longint v);
        if (v > ACC_HI)
            return ACC_HI;
        if (v < ACC_LO)
            return ACC_LO;
        return v;
    endfunction

    // returns 1 when the beat closes a round, with the mixed output in res
    function automatic bit mixer_accept_beat(input cmd_e cmd, input logic [2:0] slot,
                                             input logic signed [15:0] value, input logic last,
                                             output mix_res_t res);
        longint prod;
        longint mn;
        longint mx;
        longint t;
        longint s;
        longint q;
        bit     keep_neg;
        bit     keep_pos;
        res = '0;
        if (cmd == CMD_LOAD)
        begin
            gain_q[slot] = value;
            return 1'b0;
        end
        prod = longint'(value) * longint'(gain_q[slot]);
        if (cfg_thr < 4'd8 && {1'b0, slot} == cfg_thr)
            thr_acc = clamp_acc(thr_acc + prod);
        else if (prod > 0)
            pos_acc = clamp_acc(pos_acc + prod);
        else if (prod < 0)
            neg_acc = clamp_acc(neg_acc + prod);
        if (!last)
            return 1'b0;

        mn = longint'(cfg_min) * 32768;
        mx = longint'(cfg_max) * 32768;
        if (cfg_thr < 4'd8)
        begin
            t = thr_acc;
            keep_neg = 1'b1;
            keep_pos = 1'b1;
            if (t < mn)
            begin
                keep_neg = 1'b0;
                t = mn;
            end
            if (t > mx)
            begin
                keep_pos = 1'b0;
                t = mx;
            end
            s = t;
            if (keep_neg)
                s = s + neg_acc;
            if (keep_pos)
                s = s + pos_acc;
        end
        else
        begin
            s = thr_acc + pos_acc + neg_acc;
        end
        if (s < mn)
            s = mn;
        if (s > mx)
            s = mx;
        pos_acc = 0;
        neg_acc = 0;
        thr_acc = 0;

        if ((s >= 0 && mx <= 0) || (s < 0 && mn >= 0))
        begin
            res.fault = 1'b1;
            return 1'b1;
        end
        if (s >= 0)
            q = (32768 - longint'(cfg_trim)) * s / mx + longint'(cfg_trim);
        else
            q = (32768 + longint'(cfg_trim)) * (mn - s) / mn - 32768;
        if (q > 32767)
            q = 32767;
        if (q < -32768)
            q = -32768;
        res.mixed = 16'(q);
        return 1'b1;
    endfunction

    function automatic logic signed [15:0] pick_gain();
        logic signed [15:0] g;
        case ($urandom_range(3))
            0: g = 16'($urandom);
            1: g = ($urandom_range(1) == 0) ? 16'sh7fff : 16'sh8000;
            default:
            begin
                g = 16'($urandom_range(8192));
                g = g - 16'sd4096;
            end
        endcase
        return g;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_outputs.size() == 0)
            begin
                err_count++;
                if (err_count < 100)
                    $display("%0t: unexpected beat mixed_out %0d div_fault %0b",
                             $time, $signed(m_tdata), m_tuser);
            end
            else
            begin
                want = pending_outputs.pop_front();
                if (m_tdata !== want.mixed || m_tuser !== want.fault)
                begin
                    err_count++;
                    if (err_count < 100)
                        $display("%0t: mismatch exp mixed_out %0d div_fault %0b got %0d %0b",
                                 $time, want.mixed, want.fault, $signed(m_tdata), m_tuser);
                end
            end
        end
        m_tready <= (int'($urandom_range(99)) >= stall_pct);
    end

    task automatic send_beat(input cmd_e cmd, input logic [2:0] slot,
                             input logic signed [15:0] value, input logic last,
                             input logic typed, input mix_res_t typed_res);
        int       gap;
        mix_res_t got;
        gap = 0;
        while (int'($urandom_range(99)) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, value, slot};
        s_tuser  <= cmd;
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
        if (cmd == CMD_SAMPLE)
            samples_sent++;
        if (mixer_accept_beat(cmd, slot, value, last, got))
            pending_outputs.push_back(typed ? typed_res : got);
    endtask

    // block idle: every result back, then a further drain wait
    task automatic settle_idle();
        s_tvalid <= 1'b0;
        while (pending_outputs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input reg_idx_e idx, input logic [15:0] val);
        logic [31:0] word;
        word = (idx == REG_THROTTLE_SLOT) ? {28'd0, val[3:0]} : {{16{val[15]}}, val};
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            REG_OUT_MIN:       cfg_min = val;
            REG_OUT_MAX:       cfg_max = val;
            REG_TRIM:          cfg_trim = val;
            REG_THROTTLE_SLOT: cfg_thr = val[3:0];
            default:           ;
        endcase
        // read back
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if ((idx == REG_THROTTLE_SLOT) ? (prdata[3:0] !== val[3:0]) : (prdata[15:0] !== val))
        begin
            err_count++;
            if (err_count < 100)
                $display("%0t: register %s readback exp %h got %h",
                         $time, idx.name(), val, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input int mode);
        logic signed [15:0] lo;
        logic signed [15:0] hi;
        logic signed [15:0] tr;
        logic [3:0]         th;
        case (mode)
            0:
            begin
                lo = -16'sd4096;
                hi = 16'sd4096;
                tr = 16'sd0;
                th = 4'd8;
            end
            1:
            begin
                lo = -16'($urandom_range(1, 16384));
                hi = 16'($urandom_range(1, 16384));
                tr = 16'($urandom);
                th = 4'($urandom_range(8));
            end
            2:
            begin
                lo = 16'sh8000;
                hi = 16'sh7fff;
                tr = ($urandom_range(1) == 0) ? 16'sh7fff : 16'sh8000;
                th = 4'($urandom_range(7));
            end
            default:
            begin
                lo = 16'($urandom);
                hi = 16'($urandom);
                tr = 16'($urandom);
                th = 4'($urandom);
            end
        endcase
        write_register(REG_OUT_MIN, lo);
        write_register(REG_OUT_MAX, hi);
        write_register(REG_TRIM, tr);
        write_register(REG_THROTTLE_SLOT, th);
    endtask

    task automatic mixing_round();
        int         n_samples;
        logic [2:0] sl;
        logic [15:0] v;
        if ($urandom_range(9) == 0)
        begin
            // stray loads with last set
            repeat ($urandom_range(1, 3))
                send_beat(CMD_LOAD, 3'($urandom), pick_gain(), 1'b1, 1'b0, '0);
            return;
        end
        repeat ($urandom_range(2))
            send_beat(CMD_LOAD, 3'($urandom), pick_gain(), 1'($urandom), 1'b0, '0);
        n_samples = $urandom_range(1, 8);
        for (int k = 0; k < n_samples; k++)
        begin
            if ($urandom_range(7) == 0)
                send_beat(CMD_LOAD, 3'($urandom), pick_gain(), 1'b0, 1'b0, '0);
            if (cfg_thr < 4'd8 && $urandom_range(2) == 0)
                sl = cfg_thr[2:0];
            else
                sl = 3'($urandom);
            v = ($urandom_range(15) == 0) ? pick_gain() : 16'($urandom);
            send_beat(CMD_SAMPLE, sl, v, k == n_samples - 1, 1'b0, '0);
        end
    endtask

    initial
    begin
        int phase_start;
        for (int i = 0; i < GAIN_DEPTH; i++)
            gain_q[i] = '0;
        pos_acc  = 0;
        neg_acc  = 0;
        thr_acc  = 0;
        cfg_min  = -16'sd4096;
        cfg_max  = 16'sd4096;
        cfg_trim = 16'sd0;
        cfg_thr  = 4'd8;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
        begin
            if (DIRECTED[i].kind == ROW_CFG)
            begin
                settle_idle();
                write_register(DIRECTED[i].regsel, DIRECTED[i].value);
            end
            else
            begin
                send_beat(DIRECTED[i].cmd, DIRECTED[i].slot, DIRECTED[i].value,
                          DIRECTED[i].last, DIRECTED[i].typed,
                          '{DIRECTED[i].typ_out, DIRECTED[i].typ_fault});
            end
        end

        for (int ph = 0; ph < 12; ph++)
        begin
            settle_idle();
            set_config((ph + ph / 4) % 4);
            idle_pct  = SEND_IDLE[ph % 4];
            stall_pct = RECV_STALL[ph % 4];
            phase_start = samples_sent;
            while (samples_sent - phase_start < PHASE_SAMPLES)
                mixing_round();
        end

        // accumulator saturation
        settle_idle();
        idle_pct  = 0;
        stall_pct = 0;
        set_config(0);
        write_register(REG_OUT_MIN, 16'sh8000);
        write_register(REG_OUT_MAX, 16'sh7fff);
        send_beat(CMD_LOAD, 3'd3, 16'sh8000, 1'b0, 1'b0, '0);
        for (int k = 0; k < OVERFLOW_BEATS; k++)
            send_beat(CMD_SAMPLE, 3'd3, 16'sh8000, k == OVERFLOW_BEATS - 1, 1'b0, '0);

        settle_idle();
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* files.f */
sv/tggm_pkg.sv
sv/tggm_div.sv
sv/throttle_gated_gain_mixer_unit.sv
verif/tb_top.sv
